// ----- hw/rtl/sclim_pkg.sv -----
`default_nettype none

package sclim_pkg;

    // Pipeline depth, input register to output register
    localparam int NSTAGE = 8;

    // Full scale of the Q1.15 format, also the largest usable level
    localparam logic [15:0] FULL_SCALE = 16'd32768;

    // Largest positive sample
    localparam logic [15:0] POS_MAX = 16'd32767;

    // Level after reset (about 0.7 of full scale)
    localparam logic [15:0] LEVEL_RESET = 16'd22938;

    // Knee: 5*|x| above 4.0 in Q.15 enters the curve
    localparam logic [18:0] KNEE_NUM = 19'd131072;

    // 3.0 in Q.15, used as 3 - 2t
    localparam logic [16:0] THREE_Q15 = 17'd98304;

    // ceil(2^18 / 5), exact for dividends below 2^18
    localparam logic [15:0] RECIP5 = 16'd52429;

endpackage

`default_nettype wire

// ----- hw/rtl/sclim_datapath.sv -----
`default_nettype none

module sclim_datapath (
    input  wire logic                        clk,
    input  wire logic [sclim_pkg::NSTAGE-1:0] en,
    input  wire logic [15:0]                 sample_in,
    input  wire logic                        last_in,
    input  wire logic [15:0]                 level,
    output logic      [15:0]                 sample_out,
    output logic                             last_out
);
    import sclim_pkg::*;

    // stage 1: magnitude and sign
    logic [16:0] a1_next;
    logic [16:0] a1_reg;
    logic        neg1_reg;
    logic [15:0] lvl1_reg;
    logic        last1_reg;

    // stage 2: knee test, curve variable, linear product
    logic [18:0] a5;
    logic        curve2_next;
    logic [15:0] tn2_next;
    logic [32:0] lin_full;
    logic [30:0] lin2_reg;
    logic [15:0] tn2_reg;
    logic        curve2_reg;
    logic        neg2_reg;
    logic [15:0] lvl2_reg;
    logic        last2_reg;

    // stage 3: t^2 and (3 - 2t)
    logic [31:0] sq_full;
    logic [16:0] w3_next;
    logic [30:0] sq3_reg;
    logic [16:0] w3_reg;
    logic [15:0] lin3_reg;
    logic        curve3_reg;
    logic        neg3_reg;
    logic [15:0] lvl3_reg;
    logic        last3_reg;

    // stage 4: curve numerator
    logic [47:0] num_full;
    logic [45:0] num4_reg;
    logic [15:0] lin4_reg;
    logic        curve4_reg;
    logic        neg4_reg;
    logic [15:0] lvl4_reg;
    logic        last4_reg;

    // stage 5: level times (4 + num) as two partial products
    logic [47:0] s_val;
    logic [39:0] pp_hi5_reg;
    logic [39:0] pp_lo5_reg;
    logic [15:0] lin5_reg;
    logic        curve5_reg;
    logic        neg5_reg;
    logic        last5_reg;

    // stage 6: sum and drop the 2^45 scale
    logic [40:0] psum;
    logic [17:0] q6_reg;
    logic [15:0] lin6_reg;
    logic        curve6_reg;
    logic        neg6_reg;
    logic        last6_reg;

    // stage 7: divide by five through the reciprocal
    logic [33:0] prod7_reg;
    logic [15:0] lin7_reg;
    logic        curve7_reg;
    logic        neg7_reg;
    logic        last7_reg;

    // stage 8: select, sign, saturate
    logic [15:0] mag8;
    logic [15:0] res8_next;
    logic [15:0] res8_reg;
    logic        last8_reg;

    assign a1_next = sample_in[15] ? (17'h10000 - {1'b0, sample_in}) : {1'b0, sample_in};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a1_reg    <= a1_next;
            neg1_reg  <= sample_in[15];
            lvl1_reg  <= level;
            last1_reg <= last_in;
        end
    end

    always_comb
    begin
        a5          = {a1_reg, 2'b00} + {2'b00, a1_reg};
        curve2_next = (a5 > KNEE_NUM);
        tn2_next    = curve2_next ? 16'(a5 - KNEE_NUM) : 16'd0;
        lin_full    = a1_reg * lvl1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            lin2_reg   <= lin_full[30:0];
            tn2_reg    <= tn2_next;
            curve2_reg <= curve2_next;
            neg2_reg   <= neg1_reg;
            lvl2_reg   <= lvl1_reg;
            last2_reg  <= last1_reg;
        end
    end

    always_comb
    begin
        sq_full = tn2_reg * tn2_reg;
        w3_next = THREE_Q15 - {tn2_reg, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            sq3_reg    <= sq_full[30:0];
            w3_reg     <= w3_next;
            lin3_reg   <= lin2_reg[30:15];
            curve3_reg <= curve2_reg;
            neg3_reg   <= neg2_reg;
            lvl3_reg   <= lvl2_reg;
            last3_reg  <= last2_reg;
        end
    end

    assign num_full = sq3_reg * w3_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            num4_reg   <= num_full[45:0];
            lin4_reg   <= lin3_reg;
            curve4_reg <= curve3_reg;
            neg4_reg   <= neg3_reg;
            lvl4_reg   <= lvl3_reg;
            last4_reg  <= last3_reg;
        end
    end

    // num never exceeds 2^45, so adding 4*2^45 is a plain concatenation
    assign s_val = {2'b10, num4_reg};

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            pp_hi5_reg <= lvl4_reg * s_val[47:24];
            pp_lo5_reg <= lvl4_reg * s_val[23:0];
            lin5_reg   <= lin4_reg;
            curve5_reg <= curve4_reg;
            neg5_reg   <= neg4_reg;
            last5_reg  <= last4_reg;
        end
    end

    // floor(P / 2^45) with P = pp_hi * 2^24 + pp_lo
    assign psum = {1'b0, pp_hi5_reg} + {25'd0, pp_lo5_reg[39:24]};

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            q6_reg     <= psum[38:21];
            lin6_reg   <= lin5_reg;
            curve6_reg <= curve5_reg;
            neg6_reg   <= neg5_reg;
            last6_reg  <= last5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            prod7_reg  <= q6_reg * RECIP5;
            lin7_reg   <= lin6_reg;
            curve7_reg <= curve6_reg;
            neg7_reg   <= neg6_reg;
            last7_reg  <= last6_reg;
        end
    end

    // magnitude is at most full scale; negative side holds -32768 exactly
    always_comb
    begin
        mag8 = curve7_reg ? prod7_reg[33:18] : lin7_reg;
        if (neg7_reg)
        begin
            res8_next = 16'd0 - mag8;
        end
        else
        begin
            res8_next = (mag8 > POS_MAX) ? POS_MAX : mag8;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            res8_reg  <= res8_next;
            last8_reg <= last7_reg;
        end
    end

    assign sample_out = res8_reg;
    assign last_out   = last8_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/soft_clip_volume_limiter_core.sv -----
// Smoothstep soft clipper with a programmable ceiling.
// Pipelined: a sample passes through each datapath stage register from input request to output request.
// Throughput: one sample per cycle; stalls hold each stage, empty stages fill up.
// Reset (rst_n low, async): pipeline empty, level returns to 22938 (about 0.7).
`default_nettype none

module soft_clip_volume_limiter_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: max_level
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample_in
    input  wire logic        s_axis_tlast,   // frame_last_in
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // [15:0] sample_out
    output logic             m_axis_tlast    // frame_last_out
);
    import sclim_pkg::*;

    logic [15:0]       level_reg;
    logic [15:0]       level_eff;
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE:0]   ready;
    logic [NSTAGE-1:0] en;
    logic [16:0]       out_mag;

    // level register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= LEVEL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            level_reg <= cfg_data;
        end
    end

    assign level_eff = (level_reg > FULL_SCALE) ? FULL_SCALE : level_reg;

    // per-stage ready chain: a stage moves when empty or its successor moves
    always_comb
    begin
        ready[NSTAGE] = m_axis_tready;
        for (int k = NSTAGE - 1; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k + 1];
        end
        for (int k = 0; k < NSTAGE; k++)
        begin
            valid_next[k] = (k == 0) ? s_axis_tvalid : valid_reg[(k == 0) ? 0 : k - 1];
            en[k]         = ready[k] && valid_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTAGE; k++)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    assign s_axis_tready = ready[0];
    assign m_axis_tvalid = valid_reg[NSTAGE-1];

    sclim_datapath u_datapath (
        .clk        (clk),
        .en         (en),
        .sample_in  (s_axis_tdata),
        .last_in    (s_axis_tlast),
        .level      (level_eff),
        .sample_out (m_axis_tdata),
        .last_out   (m_axis_tlast)
    );

    // magnitude of the delivered sample
    assign out_mag = m_axis_tdata[15] ? (17'h10000 - {1'b0, m_axis_tdata})
                                      : {1'b0, m_axis_tdata};

    // a partly empty pipeline always takes a new request
    assert property (@(posedge clk) disable iff (!rst_n)
        !(&valid_reg) |-> s_axis_tready)
        else $error("input stalled with an empty stage");

    // output never exceeds the ceiling
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_mag <= {1'b0, level_eff}))
        else $error("output magnitude above level");

    // a held output request keeps its sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output changed");

endmodule

`default_nettype wire
